>>> rtl/core/light_and_fog_shading_core_defines.svh
// assertion macros used by the checker file
`ifndef LIGHT_AND_FOG_SHADING_CORE_DEFINES_SVH
`define LIGHT_AND_FOG_SHADING_CORE_DEFINES_SVH

// same-cycle implication, masked while reset is asserted
`define LFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked while reset is asserted
`define LFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// checked through reset: what must hold in the cycle after reset is seen
`define LFS_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/lfs_pkg.sv
// ----------------------------------------------------------------------------
// lfs_pkg
// types and constants of the light and fog shading pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package lfs_pkg;

  localparam int unsigned FULL_LIGHT  = 256;
  localparam int unsigned LIGHT_RANGE = 64;
  localparam int unsigned SHADE_SHIFT = 10;

  // pipeline layout: operand stage, normalize stage, divider setup,
  // one divider stage per quotient bit, two multiply stages
  localparam int unsigned DIV_STEPS = 8;
  localparam int unsigned STG_DIV0  = 3;
  localparam int unsigned STG_M1    = STG_DIV0 + DIV_STEPS;
  localparam int unsigned STG_OUT   = STG_M1 + 1;
  localparam int unsigned NSTG      = STG_OUT + 1;

  // colors and destination riding along the pipeline
  typedef struct packed {
    logic [7:0] lr;
    logic [7:0] lg;
    logic [7:0] lb;
    logic [7:0] fr;
    logic [7:0] fg;
    logic [7:0] fb;
    logic       act;
  } side_t;

  typedef struct packed {
    logic [32:0] num;   // distance - fog_stop, two's complement
    logic [32:0] den;   // fog_start - fog_stop, two's complement
    logic [23:0] t;     // light diminish term
    logic [8:0]  lvl;
    side_t       side;
  } s1_t;

  typedef struct packed {
    logic [32:0] num;   // sign-normalized numerator
    logic [31:0] den;   // magnitude of denominator
    logic        den_zero;
    logic        num_pos;
    logic [8:0]  li;
    side_t       side;
  } s2_t;

  typedef struct packed {
    logic        done;
    logic [8:0]  q;
    logic [31:0] rem;
    logic [31:0] den;
    logic [8:0]  li;
    side_t       side;
  } div_t;

  typedef struct packed {
    logic [8:0]  u;
    logic [15:0] fog_color;
    logic [7:0]  lr;
    logic [7:0]  lg;
    logic [7:0]  lb;
    logic        act;
  } m1_t;

endpackage

`default_nettype wire

>>> rtl/core/light_and_fog_shading_core.sv
// ----------------------------------------------------------------------------
// light_and_fog_shading_core: diminished light and linear depth fog per column
// throughput one transaction per cycle while the output is not stalled; 8-stage
// restoring fog divider (one quotient bit per stage, one 33-bit compare each)
// stages advance independently, bubbles collapse; reset empties the pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module light_and_fog_shading_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_distance,
  input  wire logic [31:0] in_proj_scale,
  input  wire logic [8:0]  in_light_level,
  input  wire logic [7:0]  in_light_red,
  input  wire logic [7:0]  in_light_green,
  input  wire logic [7:0]  in_light_blue,
  input  wire logic [31:0] in_fog_start,
  input  wire logic [31:0] in_fog_stop,
  input  wire logic [7:0]  in_fog_red,
  input  wire logic [7:0]  in_fog_green,
  input  wire logic [7:0]  in_fog_blue,
  input  wire logic        in_action,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_fog_color,
  output logic [5:0]       out_shade_red,
  output logic [5:0]       out_shade_green,
  output logic [5:0]       out_shade_blue,
  output logic             out_destination
);

  localparam int unsigned NSTG      = lfs_pkg::NSTG;
  localparam int unsigned DIV_STEPS = lfs_pkg::DIV_STEPS;

  // --------------------------------------------------------------------------
  // flow control: a stage loads when it is empty or its successor moves on
  // --------------------------------------------------------------------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] vld_shift;
  logic [NSTG:0]   rdy;

  always_comb begin
    rdy[NSTG] = !out_stall;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign vld_shift = {vld_r[NSTG-2:0], in_valid};

  always_comb begin
    for (int i = 0; i < NSTG; i++) begin
      vld_nxt[i] = rdy[i] ? vld_shift[i] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall = !rdy[0];

  // --------------------------------------------------------------------------
  // stage 1: fog differences and the light diminish product
  // --------------------------------------------------------------------------
  lfs_pkg::s1_t s1_r, s1_nxt;
  logic [9:0]   diff_w;
  logic [40:0]  dim_prod;

  always_comb begin
    // 256 - level; only used when level <= 256, so it fits nine bits
    diff_w   = 10'(lfs_pkg::FULL_LIGHT) - {1'b0, in_light_level};
    dim_prod = {32'b0, diff_w[8:0]} * {9'b0, in_proj_scale};

    s1_nxt.num      = {in_distance[31], in_distance} - {in_fog_stop[31], in_fog_stop};
    s1_nxt.den      = {in_fog_start[31], in_fog_start} - {in_fog_stop[31], in_fog_stop};
    s1_nxt.t        = dim_prod[40:17];   // product / 2, then drop 16 fraction bits
    s1_nxt.lvl      = in_light_level;
    s1_nxt.side.lr  = in_light_red;
    s1_nxt.side.lg  = in_light_green;
    s1_nxt.side.lb  = in_light_blue;
    s1_nxt.side.fr  = in_fog_red;
    s1_nxt.side.fg  = in_fog_green;
    s1_nxt.side.fb  = in_fog_blue;
    s1_nxt.side.act = in_action;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_r <= s1_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: sign-normalize the fog ratio, clamp the diminished light
  // --------------------------------------------------------------------------
  lfs_pkg::s2_t s2_r, s2_nxt;
  logic [32:0]  den_abs;
  logic [6:0]   lim;
  logic         bright;

  always_comb begin
    // a negative denominator flips both signs
    den_abs        = s1_r.den[32] ? (~s1_r.den + 33'd1) : s1_r.den;
    s2_nxt.num     = s1_r.den[32] ? (~s1_r.num + 33'd1) : s1_r.num;
    s2_nxt.den     = den_abs[31:0];
    s2_nxt.den_zero = (s1_r.den == '0);
    s2_nxt.num_pos = !s1_r.num[32] && (s1_r.num != '0);
    s2_nxt.side    = s1_r.side;

    // light floor is level - min(level, 64)
    bright = (s1_r.lvl > 9'(lfs_pkg::FULL_LIGHT));
    lim    = (s1_r.lvl >= 9'(lfs_pkg::LIGHT_RANGE)) ? 7'(lfs_pkg::LIGHT_RANGE)
                                                     : s1_r.lvl[6:0];
    priority if (bright) begin
      // above full bright the term raises the level, so it clamps at the top
      s2_nxt.li = 9'(lfs_pkg::FULL_LIGHT);
    end else if (s1_r.t > {17'b0, lim}) begin
      s2_nxt.li = s1_r.lvl - {2'b0, lim};
    end else begin
      s2_nxt.li = s1_r.lvl - s1_r.t[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_r <= s2_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: fraction special cases, divider setup
  // --------------------------------------------------------------------------
  lfs_pkg::div_t s3_r, s3_nxt;

  always_comb begin
    s3_nxt.den  = s2_r.den;
    s3_nxt.li   = s2_r.li;
    s3_nxt.side = s2_r.side;
    s3_nxt.rem  = s2_r.num[31:0];
    s3_nxt.done = 1'b1;
    s3_nxt.q    = '0;
    priority if (s2_r.den_zero) begin
      // equal start and stop: step function on the numerator sign
      s3_nxt.q = s2_r.num_pos ? 9'(lfs_pkg::FULL_LIGHT) : 9'd0;
    end else if (s2_r.num[32]) begin
      s3_nxt.q = 9'd0;
    end else if (s2_r.num[31:0] >= s2_r.den) begin
      s3_nxt.q = 9'(lfs_pkg::FULL_LIGHT);
    end else begin
      s3_nxt.done = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_r <= s3_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stages 4..11: restoring divider, one quotient bit per stage
  // --------------------------------------------------------------------------
  function automatic lfs_pkg::div_t div_step(input lfs_pkg::div_t d);
    lfs_pkg::div_t r;
    logic [32:0]   r2;
    logic [32:0]   diff;
    logic          ge;
    r    = d;
    r2   = {d.rem, 1'b0};
    diff = r2 - {1'b0, d.den};
    ge   = (r2 >= {1'b0, d.den});
    if (!d.done) begin
      r.rem = ge ? diff[31:0] : r2[31:0];
      r.q   = {d.q[7:0], ge};
    end
    return r;
  endfunction

  lfs_pkg::div_t dv_r   [DIV_STEPS];
  lfs_pkg::div_t dv_nxt [DIV_STEPS];

  always_comb begin
    dv_nxt[0] = div_step(s3_r);
    for (int k = 1; k < DIV_STEPS; k++) begin
      dv_nxt[k] = div_step(dv_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (rdy[lfs_pkg::STG_DIV0 + k]) begin
        dv_r[k] <= dv_nxt[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 12: fogged light level and packed fog color
  // --------------------------------------------------------------------------
  lfs_pkg::m1_t m1_r, m1_nxt;
  logic [8:0]   frac;
  logic [8:0]   fog_w;
  logic [17:0]  u_full;
  logic [16:0]  red_w, grn_w, blu_w;

  always_comb begin
    frac   = dv_r[DIV_STEPS-1].q;
    fog_w  = 9'(lfs_pkg::FULL_LIGHT) - frac;
    u_full = {9'b0, dv_r[DIV_STEPS-1].li} * {9'b0, frac};
    red_w  = {9'b0, dv_r[DIV_STEPS-1].side.fr} * {8'b0, fog_w};
    grn_w  = {9'b0, dv_r[DIV_STEPS-1].side.fg} * {8'b0, fog_w};
    blu_w  = {9'b0, dv_r[DIV_STEPS-1].side.fb} * {8'b0, fog_w};

    m1_nxt.u         = u_full[16:8];
    // 5-5-5 with a dead bit between green and blue
    m1_nxt.fog_color = {red_w[15:11], grn_w[15:11], 1'b0, blu_w[15:11]};
    m1_nxt.lr        = dv_r[DIV_STEPS-1].side.lr;
    m1_nxt.lg        = dv_r[DIV_STEPS-1].side.lg;
    m1_nxt.lb        = dv_r[DIV_STEPS-1].side.lb;
    m1_nxt.act       = dv_r[DIV_STEPS-1].side.act;
  end

  always_ff @(posedge clk) begin
    if (rdy[lfs_pkg::STG_M1]) begin
      m1_r <= m1_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 13: shade multipliers into the output register
  // --------------------------------------------------------------------------
  logic [16:0] sr_prod, sg_prod, sb_prod;

  always_comb begin
    sr_prod = {8'b0, m1_r.u} * {9'b0, m1_r.lr};
    sg_prod = {8'b0, m1_r.u} * {9'b0, m1_r.lg};
    sb_prod = {8'b0, m1_r.u} * {9'b0, m1_r.lb};
  end

  always_ff @(posedge clk) begin
    if (rdy[lfs_pkg::STG_OUT]) begin
      out_fog_color   <= m1_r.fog_color;
      out_shade_red   <= sr_prod[lfs_pkg::SHADE_SHIFT +: 6];
      out_shade_green <= sg_prod[lfs_pkg::SHADE_SHIFT +: 6];
      out_shade_blue  <= sb_prod[lfs_pkg::SHADE_SHIFT +: 6];
      out_destination <= m1_r.act;
    end
  end

  assign out_valid = vld_r[lfs_pkg::STG_OUT];

endmodule

`default_nettype wire

>>> rtl/core/lfs_checker.sv
// ----------------------------------------------------------------------------
// lfs_checker
// port-level checks of the light and fog shading core
// ----------------------------------------------------------------------------
`default_nettype none

`include "light_and_fog_shading_core_defines.svh"

module lfs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_fog_color,
  input wire logic [5:0]  out_shade_red,
  input wire logic [5:0]  out_shade_green,
  input wire logic [5:0]  out_shade_blue,
  input wire logic        out_destination
);

  // stalled result transaction holds
  `LFS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_fog_color) && $stable(out_shade_red) && $stable(out_shade_green) && $stable(out_shade_blue) && $stable(out_destination), "stalled result changed")

  // with the output moving or empty, bubbles collapse up to the input
  `LFS_ASSERT_IMP(a_no_false_stall, !out_valid || !out_stall, !in_stall, "input stalled with free pipeline")

  // the bit between green and blue is never set
  `LFS_ASSERT_IMP(a_fog_gap, out_valid, !out_fog_color[5], "fog color gap bit set")

  // reset empties the pipeline
  `LFS_ASSERT_RST(a_rst_empty, !out_valid, "result valid after reset")

endmodule

bind light_and_fog_shading_core lfs_checker u_lfs_checker (.*);

`default_nettype wire
